// File: rtl/core/accel_fall_motion_detector_macros.svh
// ----------------------------------------------------------------------------
// accel_fall_motion_detector assertion macros
// Shared property wrappers for the detector's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ACCEL_FALL_MOTION_DETECTOR_MACROS_SVH
`define ACCEL_FALL_MOTION_DETECTOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define AFMD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("afmd check failed");

// next-cycle implication, disabled during reset
`define AFMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("afmd check failed");

`endif

// File: rtl/core/afmd_pkg.sv
// ----------------------------------------------------------------------------
// afmd_pkg
// Types, codes and reset constants for the fall and motion detector.
// ----------------------------------------------------------------------------
package afmd_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int FIELD_WIDTH      = 16;
  localparam int THR_WIDTH        = 15;
  localparam int CNT_WIDTH        = 8;
  localparam int DATA_WIDTH       = 32;
  localparam int ADDR_WIDTH       = 4;

  // register reset values
  localparam logic [THR_WIDTH-1:0] MOVE_THR_RST   = 15'd20;
  localparam logic [THR_WIDTH-1:0] JUMP_THR_RST   = 15'd700;
  localparam logic [CNT_WIDTH-1:0] STILL_LIMIT_RST = 8'd10;
  localparam logic [CNT_WIDTH-1:0] CNT_MAX         = 8'hFF;

  // register indexes (word address bits)
  localparam logic [1:0] REG_MOVE_THR    = 2'd0;
  localparam logic [1:0] REG_JUMP_THR    = 2'd1;
  localparam logic [1:0] REG_STILL_LIMIT = 2'd2;

  // event opcodes
  localparam logic [1:0] OP_SLOW = 2'd0;
  localparam logic [1:0] OP_FAST = 2'd1;
  localparam logic [1:0] OP_POLL = 2'd2;

  typedef enum logic [2:0] {
    MSG_NONE   = 3'd0,
    MSG_MOVING = 3'd1,
    MSG_DEAD   = 3'd2,
    MSG_FALL   = 3'd3,
    MSG_FLY    = 3'd4,
    MSG_TRIP   = 3'd5
  } msg_t;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_UNCON  = 3'd1,
    MODE_FALL   = 3'd2,
    MODE_FLY    = 3'd3,
    MODE_HALT   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_MAYBE_DEAD = 3'd1,
    ST_DOWN       = 3'd2,
    ST_UP         = 3'd3,
    ST_TRIP       = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [FIELD_WIDTH-1:0] accel_x;
    logic [FIELD_WIDTH-1:0] accel_y;
    logic [FIELD_WIDTH-1:0] accel_z;
  } sample_t;

  typedef struct packed {
    msg_t                 message;
    logic                 last;
    mode_t                mode_now;
    status_t              status_now;
    logic [CNT_WIDTH-1:0] still_ticks;
  } result_t;

endpackage

// File: rtl/core/accel_fall_motion_detector.sv
// ----------------------------------------------------------------------------
// accel_fall_motion_detector
// Tracks stillness, z jolts and trips from tagged accelerometer samples and
// reports a message word per event, plus a tripped word after a fall trip.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                     | words per item
//  sample   | in        | sample_valid / sample_stall   | 1
//  result   | out       | result_valid / result_stall   | 1, or 2 on a trip
//  apb      | in        | psel / penable / pwrite       | config writes
//
// One sample is taken per cycle while sample_stall is low; its result word
// shows up the cycle after. A trip adds a second word held in a pending slot,
// so the sample side stalls until the first word is taken. Result stalls back
// up into sample_stall. Synchronous reset clears all state but the result data
// and loads the register defaults; after a trip only reset leaves the halted mode.
module accel_fall_motion_detector #(
  parameter int SAMPLE_WIDTH = afmd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [afmd_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [afmd_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [afmd_pkg::DATA_WIDTH-1:0] prdata,
  output logic                            pready,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  afmd_pkg::sample_t               sample,
  output logic                            result_valid,
  input  logic                            result_stall,
  output afmd_pkg::result_t               result
);

  localparam int FW = afmd_pkg::FIELD_WIDTH;
  localparam int TW = afmd_pkg::THR_WIDTH;
  localparam int CW = afmd_pkg::CNT_WIDTH;
  localparam int EW = (SAMPLE_WIDTH > FW) ? SAMPLE_WIDTH : FW;
  localparam int DW = ((SAMPLE_WIDTH + 1 > TW + 1) ? SAMPLE_WIDTH + 1 : TW + 1) + 1;

  // configuration registers
  logic [TW-1:0] move_threshold;
  logic [TW-1:0] jump_threshold;
  logic [CW-1:0] still_limit;

  // detector state
  logic signed [SAMPLE_WIDTH-1:0] prev_x, prev_y, prev_z;
  logic [CW-1:0]                  still_count;
  afmd_pkg::status_t              status_reg;
  afmd_pkg::mode_t                mode_reg;

  // output slot and pending trip word
  logic              pend_valid;
  afmd_pkg::result_t pend_word;

  logic cfg_write;
  logic accept;
  logic take;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      move_threshold <= afmd_pkg::MOVE_THR_RST;
      jump_threshold <= afmd_pkg::JUMP_THR_RST;
      still_limit    <= afmd_pkg::STILL_LIMIT_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        afmd_pkg::REG_MOVE_THR:    move_threshold <= pwdata[TW-1:0];
        afmd_pkg::REG_JUMP_THR:    jump_threshold <= pwdata[TW-1:0];
        afmd_pkg::REG_STILL_LIMIT: still_limit    <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (paddr[3:2])
      afmd_pkg::REG_MOVE_THR:    prdata = afmd_pkg::DATA_WIDTH'(move_threshold);
      afmd_pkg::REG_JUMP_THR:    prdata = afmd_pkg::DATA_WIDTH'(jump_threshold);
      afmd_pkg::REG_STILL_LIMIT: prdata = afmd_pkg::DATA_WIDTH'(still_limit);
      default:                   prdata = '0;
    endcase
  end

  // sample sign extension from the low sample bits
  logic [EW-1:0]                  xz, yz, zz;
  logic signed [SAMPLE_WIDTH-1:0] xs, ys, zs;
  assign xz = EW'(sample.accel_x);
  assign yz = EW'(sample.accel_y);
  assign zz = EW'(sample.accel_z);
  assign xs = $signed(xz[SAMPLE_WIDTH-1:0]);
  assign ys = $signed(yz[SAMPLE_WIDTH-1:0]);
  assign zs = $signed(zz[SAMPLE_WIDTH-1:0]);

  // axis differences against the stored sample
  logic signed [DW-1:0] dx, dy, dz, mthr, jthr;
  assign dx   = DW'(xs) - DW'(prev_x);
  assign dy   = DW'(ys) - DW'(prev_y);
  assign dz   = DW'(zs) - DW'(prev_z);
  assign mthr = $signed(DW'(move_threshold));
  assign jthr = $signed(DW'(jump_threshold));

  logic moved, z_down, z_up, xy_jump;
  assign moved   = (dx > mthr) || (dx < -mthr) || (dy > mthr) || (dy < -mthr)
                || (dz > mthr) || (dz < -mthr);
  assign z_down  = dz > jthr;
  assign z_up    = dz < -jthr;
  assign xy_jump = (dx > jthr) || (dx < -jthr) || (dy > jthr) || (dy < -jthr);

  // event decode and next state
  afmd_pkg::status_t status_next, status_poll;
  afmd_pkg::mode_t   mode_next, mode_poll;
  logic [CW-1:0]     still_next;
  afmd_pkg::msg_t    msg;
  logic              tripped;
  logic              store_prev;

  always_comb begin
    status_next = status_reg;
    mode_next   = mode_reg;
    still_next  = still_count;
    msg         = afmd_pkg::MSG_NONE;
    tripped     = 1'b0;
    store_prev  = 1'b0;
    status_poll = status_reg;
    mode_poll   = mode_reg;
    if (mode_reg == afmd_pkg::MODE_NORMAL || mode_reg == afmd_pkg::MODE_UNCON ||
        mode_reg == afmd_pkg::MODE_FALL || mode_reg == afmd_pkg::MODE_FLY) begin
      case (sample.opcode)
        afmd_pkg::OP_SLOW: begin
          store_prev = 1'b1;
          if (moved) begin
            still_next  = '0;
            status_next = afmd_pkg::ST_OK;
          end else if (still_count != afmd_pkg::CNT_MAX) begin
            still_next = still_count + 1'b1;
          end
        end
        afmd_pkg::OP_FAST: begin
          if (z_down) begin
            status_next = afmd_pkg::ST_DOWN;
          end else if (z_up) begin
            status_next = afmd_pkg::ST_UP;
          end
        end
        afmd_pkg::OP_POLL: begin
          unique case (mode_reg)
            afmd_pkg::MODE_NORMAL: begin
              msg = afmd_pkg::MSG_MOVING;
              if (still_count == still_limit) begin
                status_poll = afmd_pkg::ST_MAYBE_DEAD;
                mode_poll   = afmd_pkg::MODE_UNCON;
              end
              // man down goes to fly, man up to fall
              if (status_poll == afmd_pkg::ST_DOWN) begin
                mode_poll = afmd_pkg::MODE_FLY;
              end else if (status_poll == afmd_pkg::ST_UP) begin
                mode_poll = afmd_pkg::MODE_FALL;
              end
              status_next = status_poll;
              mode_next   = mode_poll;
            end
            afmd_pkg::MODE_UNCON: msg = afmd_pkg::MSG_DEAD;
            afmd_pkg::MODE_FALL: begin
              msg = afmd_pkg::MSG_FALL;
              if (xy_jump) begin
                status_next = afmd_pkg::ST_TRIP;
                mode_next   = afmd_pkg::MODE_HALT;
                tripped     = 1'b1;
              end
            end
            default: msg = afmd_pkg::MSG_FLY;
          endcase
        end
        default: ;
      endcase
    end
  end

  // result words for this sample
  afmd_pkg::result_t word0, word1;
  always_comb begin
    word0.message     = msg;
    word0.last        = !tripped;
    word0.mode_now    = mode_next;
    word0.status_now  = status_next;
    word0.still_ticks = still_next;
    word1             = word0;
    word1.message     = afmd_pkg::MSG_TRIP;
    word1.last        = 1'b1;
  end

  // handshake
  assign take         = result_valid && !result_stall;
  assign sample_stall = result_valid && (result_stall || pend_valid);
  assign accept       = sample_valid && !sample_stall;

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x      <= '0;
      prev_y      <= '0;
      prev_z      <= '0;
      still_count <= '0;
      status_reg  <= afmd_pkg::ST_OK;
      mode_reg    <= afmd_pkg::MODE_NORMAL;
    end else if (accept) begin
      still_count <= still_next;
      status_reg  <= status_next;
      mode_reg    <= mode_next;
      if (store_prev) begin
        prev_x <= xs;
        prev_y <= ys;
        prev_z <= zs;
      end
    end
  end

  // output slot and pending slot
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
      pend_valid   <= tripped;
    end else if (take) begin
      result_valid <= pend_valid;
      pend_valid   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result    <= word0;
      pend_word <= word1;
    end else if (take && pend_valid) begin
      result <= pend_word;
    end
  end

`include "accel_fall_motion_detector_macros.svh"

  `AFMD_ASSERT_NOW(a_pend_has_slot, pend_valid, result_valid && !result.last)
  `AFMD_ASSERT_NOW(a_pend_is_trip, pend_valid, pend_word.message == afmd_pkg::MSG_TRIP && mode_reg == afmd_pkg::MODE_HALT)
  `AFMD_ASSERT_NEXT(a_trip_two_words, accept && tripped, result_valid && pend_valid)
  `AFMD_ASSERT_NEXT(a_halt_sticks, mode_reg == afmd_pkg::MODE_HALT, mode_reg == afmd_pkg::MODE_HALT)

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fall and motion detector. Each accepted sample
// word runs through an in-bench detector predictor, and every result word is
// checked field by field in arrival order. The run covers the default
// thresholds, the extreme thresholds, random settings, a long receiver
// hold-off, and finally a fall that ends in a trip and the halted mode.
// ----------------------------------------------------------------------------
module tb;
  import afmd_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] REG_UNUSED  = 2'd3;
  localparam int         IDLE_PCT    = 7;
  localparam int         HOLD_CYCLES = 100;
  localparam int         STALL_LIMIT = 2000;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr        = '0;
  logic [DATA_WIDTH-1:0] pwdata       = '0;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  sample_t               sample       = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;

  // predictor copy of the detector registers and state
  logic [THR_WIDTH-1:0]  move_limit   = MOVE_THR_RST;
  logic [THR_WIDTH-1:0]  jump_limit   = JUMP_THR_RST;
  logic [CNT_WIDTH-1:0]  still_target = STILL_LIMIT_RST;
  int                    seen_x       = 0;
  int                    seen_y       = 0;
  int                    seen_z       = 0;
  logic [CNT_WIDTH-1:0]  still_run    = '0;
  status_t               wearer_status = ST_OK;
  mode_t                 wearer_mode   = MODE_NORMAL;

  result_t               pending_reports[$];
  int                    errors       = 0;
  logic                  idle_on      = 1'b1;
  int                    hold_reqs    = 0;
  int                    hold_seen    = 0;
  int                    hold_left    = 0;
  int                    quiet_cycles = 0;

  accel_fall_motion_detector u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit beyond_thr(int diff, logic [THR_WIDTH-1:0] thr);
    return (diff > int'(thr)) || (diff < -int'(thr));
  endfunction

  // advance the detector state by one sample and queue its result words
  function automatic void forecast_reports(sample_t s);
    int      x;
    int      y;
    int      z;
    int      dz;
    msg_t    note;
    bit      tripped;
    result_t r;
    x = int'($signed(s.accel_x));
    y = int'($signed(s.accel_y));
    z = int'($signed(s.accel_z));
    note = MSG_NONE;
    tripped = 1'b0;
    // halted mode ignores everything
    if (wearer_mode < MODE_HALT) begin
      case (s.opcode)
        OP_SLOW: begin
          if (beyond_thr(x - seen_x, move_limit) || beyond_thr(y - seen_y, move_limit) ||
              beyond_thr(z - seen_z, move_limit)) begin
            still_run = '0;
            wearer_status = ST_OK;
          end else if (still_run != CNT_MAX) begin
            still_run = still_run + 1'b1;
          end
          seen_x = x;
          seen_y = y;
          seen_z = z;
        end
        OP_FAST: begin
          dz = z - seen_z;
          if (dz > int'(jump_limit)) wearer_status = ST_DOWN;
          else if (dz < -int'(jump_limit)) wearer_status = ST_UP;
        end
        OP_POLL: begin
          case (wearer_mode)
            MODE_NORMAL: begin
              note = MSG_MOVING;
              if (still_run == still_target) begin
                wearer_status = ST_MAYBE_DEAD;
                wearer_mode = MODE_UNCON;
              end
              // a drop leads to fly and a rise to fall, crossed on purpose
              if (wearer_status == ST_DOWN) wearer_mode = MODE_FLY;
              else if (wearer_status == ST_UP) wearer_mode = MODE_FALL;
            end
            MODE_UNCON: note = MSG_DEAD;
            MODE_FALL: begin
              note = MSG_FALL;
              if (beyond_thr(x - seen_x, jump_limit) || beyond_thr(y - seen_y, jump_limit)) begin
                wearer_status = ST_TRIP;
                wearer_mode = MODE_HALT;
                tripped = 1'b1;
              end
            end
            default: note = MSG_FLY;
          endcase
        end
        default: ;
      endcase
    end
    r.mode_now = wearer_mode;
    r.status_now = wearer_status;
    r.still_ticks = still_run;
    r.message = note;
    r.last = !tripped;
    pending_reports.push_back(r);
    if (tripped) begin
      r.message = MSG_TRIP;
      r.last = 1'b1;
      pending_reports.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  function automatic void compare_report(result_t want, result_t got);
    check_field("message", want.message, got.message);
    check_field("last", want.last, got.last);
    check_field("mode_now", want.mode_now, got.mode_now);
    check_field("status_now", want.status_now, got.status_now);
    check_field("still_ticks", want.still_ticks, got.still_ticks);
  endfunction

  // result side: check accepted words, then pick the next stall
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: expected no word, got %h", $time, result);
      end else begin
        compare_report(pending_reports.pop_front(), result);
      end
    end
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (result_valid && !result_stall) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [FIELD_WIDTH-1:0] shift_axis(int base, int off);
    int v;
    v = base + off;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[FIELD_WIDTH-1:0];
  endfunction

  function automatic logic [FIELD_WIDTH-1:0] near_axis(int base, int spread);
    return shift_axis(base, int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic sample_t make_sample(logic [1:0] op, int x, int y, int z);
    sample_t s;
    s.opcode = op;
    s.accel_x = x[FIELD_WIDTH-1:0];
    s.accel_y = y[FIELD_WIDTH-1:0];
    s.accel_z = z[FIELD_WIDTH-1:0];
    return s;
  endfunction

  // random sample, mostly close to the stored one; steady keeps the mode put
  function automatic sample_t pick_sample(bit steady);
    sample_t s;
    int      roll;
    int      lean;
    roll = $urandom_range(0, 99);
    if (roll < 40) s.opcode = OP_SLOW;
    else if (roll < 65) s.opcode = OP_FAST;
    else if (roll < 95) s.opcode = OP_POLL;
    else s.opcode = OP_UNUSED;
    s.accel_x = 16'($urandom);
    s.accel_y = 16'($urandom);
    s.accel_z = 16'($urandom);
    if ($urandom_range(0, 99) < 80) begin
      case (s.opcode)
        OP_SLOW: begin
          if ($urandom_range(0, 2) == 0) begin
            s.accel_x = seen_x[FIELD_WIDTH-1:0];
            s.accel_y = seen_y[FIELD_WIDTH-1:0];
            s.accel_z = seen_z[FIELD_WIDTH-1:0];
          end else begin
            s.accel_x = near_axis(seen_x, int'(move_limit) + 1);
            s.accel_y = near_axis(seen_y, int'(move_limit) + 1);
            s.accel_z = near_axis(seen_z, int'(move_limit) + 1);
          end
        end
        OP_FAST: begin
          // z right at the jump threshold, just past it, or inside it
          lean = int'(jump_limit) + int'($urandom_range(0, 1));
          if ($urandom_range(0, 2) == 0) begin
            s.accel_z = shift_axis(seen_z, $urandom_range(0, 1) ? lean : -lean);
          end else begin
            s.accel_z = near_axis(seen_z, int'(jump_limit));
          end
        end
        OP_POLL: begin
          s.accel_x = near_axis(seen_x, int'(jump_limit) + 1);
          s.accel_y = near_axis(seen_y, int'(jump_limit) + 1);
        end
        default: ;
      endcase
    end
    if (steady && s.opcode == OP_POLL) begin
      if (wearer_mode == MODE_NORMAL && (still_run == still_target ||
          wearer_status == ST_DOWN || wearer_status == ST_UP)) begin
        s.opcode = OP_SLOW;
      end else if (wearer_mode == MODE_FALL &&
                   (beyond_thr(int'($signed(s.accel_x)) - seen_x, jump_limit) ||
                    beyond_thr(int'($signed(s.accel_y)) - seen_y, jump_limit))) begin
        s.accel_x = seen_x[FIELD_WIDTH-1:0];
        s.accel_y = seen_y[FIELD_WIDTH-1:0];
      end
    end
    return s;
  endfunction

  // send one sample word, with an occasional gap before it
  task automatic offer_sample(sample_t s);
    if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    sample <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    forecast_reports(s);
  endtask

  task automatic run_random(int count, bit steady);
    repeat (count) offer_sample(pick_sample(steady));
  endtask

  // stop sending until every expected word is in
  task automatic await_reports();
    sample_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // register write: setup phase, access phase until pready, then an idle phase
  task automatic write_reg(logic [1:0] idx, logic [DATA_WIDTH-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MOVE_THR:    move_limit = value[THR_WIDTH-1:0];
      REG_JUMP_THR:    jump_limit = value[THR_WIDTH-1:0];
      REG_STILL_LIMIT: still_target = value[CNT_WIDTH-1:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- tests

  // threshold edges, axis extremes and every opcode at reset settings
  task automatic test_reset_defaults();
    offer_sample(make_sample(OP_SLOW, 0, 0, 0));
    offer_sample(make_sample(OP_SLOW, 20, -20, 20));
    offer_sample(make_sample(OP_SLOW, 41, -20, 20));
    offer_sample(make_sample(OP_SLOW, 41, -41, 20));
    offer_sample(make_sample(OP_SLOW, 32767, -32768, 32767));
    offer_sample(make_sample(OP_SLOW, -32768, 32767, -32768));
    offer_sample(make_sample(OP_FAST, 5, 5, -32068));
    offer_sample(make_sample(OP_FAST, -5, -5, -32067));
    offer_sample(make_sample(OP_SLOW, 0, 0, 0));
    offer_sample(make_sample(OP_FAST, 0, 0, -701));
    offer_sample(make_sample(OP_SLOW, 0, 0, 100));
    offer_sample(make_sample(OP_FAST, 0, 0, -600));
    offer_sample(make_sample(OP_POLL, 32767, -32768, 0));
    offer_sample(make_sample(OP_UNUSED, -1, -1, -1));
    offer_sample(make_sample(OP_FAST, 32767, -32768, 32767));
    // still tick keeps a drop status, a move clears it
    offer_sample(make_sample(OP_SLOW, 0, 0, 100));
    offer_sample(make_sample(OP_SLOW, -21, 0, 100));
  endtask

  // receiver holds off while samples keep coming
  task automatic test_backpressure();
    hold_reqs <= hold_reqs + 1;
    run_random(60, 1'b1);
    await_reports();
    run_random(300, 1'b1);
    await_reports();
  endtask

  // all thresholds at zero, then at their maximum with a saturating still run
  task automatic test_threshold_extremes();
    write_reg(REG_MOVE_THR, '0);
    write_reg(REG_JUMP_THR, '0);
    write_reg(REG_STILL_LIMIT, '0);
    run_random(200, 1'b1);
    await_reports();
    write_reg(REG_MOVE_THR, 32'd32767);
    write_reg(REG_JUMP_THR, 32'd32767);
    write_reg(REG_STILL_LIMIT, 32'd255);
    run_random(200, 1'b1);
    repeat (270) begin
      offer_sample(make_sample(OP_SLOW, int'($signed(near_axis(seen_x, 1000))),
                               int'($signed(near_axis(seen_y, 1000))),
                               int'($signed(near_axis(seen_z, 1000)))));
    end
    await_reports();
  endtask

  // random settings with junk upper bits, no idling on either side
  task automatic test_random_settings();
    idle_on <= 1'b0;
    write_reg(REG_MOVE_THR, $urandom_range(0, 63) | (32'($urandom) << THR_WIDTH));
    write_reg(REG_JUMP_THR, $urandom_range(0, 2000) | (32'($urandom) << THR_WIDTH));
    write_reg(REG_STILL_LIMIT, $urandom_range(0, 20) | (32'($urandom) << CNT_WIDTH));
    write_reg(REG_UNUSED, $urandom);
    run_random(350, 1'b1);
    await_reports();
    idle_on <= 1'b1;
  endtask

  // rise into fall mode, wander there, trip, then everything is ignored
  task automatic test_fall_and_trip();
    write_reg(REG_MOVE_THR, DATA_WIDTH'(MOVE_THR_RST));
    write_reg(REG_JUMP_THR, DATA_WIDTH'(JUMP_THR_RST));
    write_reg(REG_STILL_LIMIT, DATA_WIDTH'(STILL_LIMIT_RST));
    offer_sample(make_sample(OP_SLOW, (seen_x < 0) ? 1000 : -1000, 0, 0));
    offer_sample(make_sample(OP_FAST, 0, 0, -(int'(jump_limit) + 1)));
    offer_sample(make_sample(OP_POLL, 0, 0, 0));
    run_random(150, 1'b1);
    offer_sample(make_sample(OP_POLL,
                             (seen_x < 0) ? seen_x + int'(jump_limit) + 1
                                          : seen_x - int'(jump_limit) - 1,
                             seen_y, 0));
    run_random(40, 1'b0);
  endtask

  // sequence
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_backpressure();
    test_threshold_extremes();
    test_random_settings();
    test_fall_and_trip();
    await_reports();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/afmd_pkg.sv
rtl/core/accel_fall_motion_detector.sv
sim/tb.sv
